### sv/heartbeat_timeout_alarm_select_unit_assert.svh
// ----------------------------------------------------------------------------
// heartbeat timeout alarm select - assertion macros
// shared property wrappers, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_TIMEOUT_ALARM_SELECT_UNIT_ASSERT_SVH
`define HEARTBEAT_TIMEOUT_ALARM_SELECT_UNIT_ASSERT_SVH

// same-cycle implication
`define HTAS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HTAS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/htas_pkg.sv
// ----------------------------------------------------------------------------
// htas_pkg
// request codes, indicator codes and table entry type of the alarm selector
// ----------------------------------------------------------------------------
`default_nettype none

package htas_pkg;

	localparam int unsigned DEVICE_SLOTS_DEF = 16;

	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 32;
	localparam int unsigned MASK_W     = 16;
	localparam int unsigned PICK_W     = 5;

	localparam logic [PICK_W-1:0] NO_SLOT = 5'd16;

	localparam logic [1:0] REQ_SCAN  = 2'd0;
	localparam logic [1:0] REQ_BEAT  = 2'd1;
	localparam logic [1:0] REQ_SETUP = 2'd2;

	localparam logic [1:0] IND_BEEP  = 2'd0;
	localparam logic [1:0] IND_RED   = 2'd1;
	localparam logic [1:0] IND_GREEN = 2'd2;

	typedef struct packed {
		logic        enable;
		logic [7:0]  beep;
		logic [7:0]  level;
		logic [15:0] timeout;
	} cfg_entry_t;

endpackage

`default_nettype wire

### sv/heartbeat_timeout_alarm_select_unit.sv
// ----------------------------------------------------------------------------
// heartbeat_timeout_alarm_select_unit
// device table with heartbeat stamps, timeout scan and alarm selection
// ----------------------------------------------------------------------------
//  channel | dir | fields (lowest bit first)
//  s_*     | in  | tuser: req_type ; tdata: now_time, device_slot, new_timeout,
//          |     |   new_level, new_beep_count, new_enable
//  m_*     | out | tdata: offline_mask, alarm_slot, alarm_beep_count, indicator
//
// heartbeat and set-up transfers each do one memory write
// a scan reads one entry per cycle through the read port of the time and config
// memories, evaluates the registered read data and then loads the result register
// the result register frees the input side; a scan ending while the previous
// result is not yet taken waits in its last state for m_tready
// reset clears the entry valid bits, so every entry reads as zero until written
// ----------------------------------------------------------------------------
`default_nettype none

module heartbeat_timeout_alarm_select_unit
	import htas_pkg::*;
#(
	parameter int unsigned DEVICE_SLOTS = DEVICE_SLOTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// now_time, device_slot, new_timeout, new_level, new_beep_count, new_enable, pad
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// req_type
	input  wire logic [IN_USER_W-1:0]  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// offline_mask, alarm_slot, alarm_beep_count, indicator, pad
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	localparam int unsigned AW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
	localparam int unsigned CW = $clog2(DEVICE_SLOTS + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEVICE_SLOTS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t state_q;

	// input fields
	logic [1:0]  in_req;
	logic [31:0] in_now;
	logic [3:0]  in_slot;
	cfg_entry_t  in_cfg;
	logic        in_xfer;
	logic        slot_ok;
	logic        beat_wr;
	logic        cfg_wr;
	logic [AW-1:0] wr_addr;

	assign in_req         = s_tuser[1:0];
	assign in_now         = s_tdata[31:0];
	assign in_slot        = s_tdata[35:32];
	assign in_cfg.timeout = s_tdata[51:36];
	assign in_cfg.level   = s_tdata[59:52];
	assign in_cfg.beep    = s_tdata[67:60];
	assign in_cfg.enable  = s_tdata[68];

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign slot_ok  = (32'(in_slot) < DEVICE_SLOTS);
	assign beat_wr  = in_xfer && (in_req == REQ_BEAT) && slot_ok;
	assign cfg_wr   = in_xfer && (in_req == REQ_SETUP) && slot_ok;
	assign wr_addr  = AW'(in_slot);

	// memories and valid bits
	logic [31:0]      time_mem [DEVICE_SLOTS];
	cfg_entry_t       cfg_mem  [DEVICE_SLOTS];
	logic [DEVICE_SLOTS-1:0] time_vld_q;
	logic [DEVICE_SLOTS-1:0] cfg_vld_q;

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] rd_addr;
	logic          rd_en;

	assign rd_addr = cnt_q[AW-1:0];
	assign rd_en   = (state_q == ST_SCAN) && (cnt_q < CW'(DEVICE_SLOTS));

	logic [31:0]   time_s1;
	cfg_entry_t    cfg_s1;
	logic          tv_s1;
	logic          cv_s1;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;

	always_ff @(posedge clk) begin
		if (beat_wr) begin
			time_mem[wr_addr] <= in_now;
		end
		if (cfg_wr) begin
			cfg_mem[wr_addr] <= in_cfg;
		end
		time_s1 <= time_mem[rd_addr];
		cfg_s1  <= cfg_mem[rd_addr];
		tv_s1   <= time_vld_q[rd_addr];
		cv_s1   <= cfg_vld_q[rd_addr];
		idx_s1  <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_vld_q <= '0;
			cfg_vld_q  <= '0;
			vld_s1     <= 1'b0;
		end else begin
			if (beat_wr) begin
				time_vld_q[wr_addr] <= 1'b1;
			end
			if (cfg_wr) begin
				cfg_vld_q[wr_addr] <= 1'b1;
			end
			vld_s1 <= rd_en;
		end
	end

	// scan accumulators
	logic [31:0]       now_q;
	logic [7:0]        best_q;
	logic [PICK_W-1:0] pick_q;
	logic              any_off_q;
	logic              all_zero_q;
	logic [MASK_W-1:0] mask_q;
	logic [7:0]        work_held_q;
	logic [7:0]        held_q;

	// entry evaluation on the read data
	logic [31:0]       elapsed;
	logic              off;
	logic [7:0]        n_best;
	logic [PICK_W-1:0] n_pick;
	logic              n_any_off;
	logic              n_all_zero;
	logic [MASK_W-1:0] n_mask;
	logic [7:0]        n_held;

	always_comb begin
		elapsed    = now_q - (tv_s1 ? time_s1 : 32'd0);
		off        = vld_s1 && cv_s1 && cfg_s1.enable && (elapsed > 32'(cfg_s1.timeout));
		n_best     = best_q;
		n_pick     = pick_q;
		n_any_off  = any_off_q;
		n_all_zero = all_zero_q;
		n_mask     = mask_q;
		n_held     = work_held_q;
		if (off) begin
			n_any_off = 1'b1;
			n_mask    = mask_q | (MASK_W'(1) << idx_s1);
			if (cfg_s1.level > best_q) begin
				n_best     = cfg_s1.level;
				n_pick     = PICK_W'(idx_s1);
				n_held     = cfg_s1.beep;
				n_all_zero = (cfg_s1.beep == 8'd0);
			end else if (cfg_s1.level == best_q && cfg_s1.beep != 8'd0) begin
				n_all_zero = 1'b0;
				if (work_held_q == 8'd0 || cfg_s1.beep < work_held_q) begin
					n_pick = PICK_W'(idx_s1);
					n_held = cfg_s1.beep;
				end
			end
		end
	end

	// outcome of a finished scan
	logic [1:0] fin_ind;
	logic [7:0] fin_held;
	logic       out_free;

	always_comb begin
		fin_held = work_held_q;
		if (pick_q != NO_SLOT && any_off_q && !all_zero_q) begin
			fin_ind = IND_BEEP;
		end else if (any_off_q && all_zero_q) begin
			fin_ind = IND_RED;
		end else begin
			fin_ind  = IND_GREEN;
			fin_held = 8'd0;
		end
	end

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			held_q      <= 8'd0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
			now_q       <= '0;
			best_q      <= '0;
			pick_q      <= NO_SLOT;
			any_off_q   <= 1'b0;
			all_zero_q  <= 1'b1;
			mask_q      <= '0;
			work_held_q <= '0;
		end else begin
			// the finishing state sets the valid itself when it loads a new result
			if (m_tvalid && m_tready && state_q != ST_FIN) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && in_req == REQ_SCAN) begin
						now_q       <= in_now;
						best_q      <= 8'd0;
						pick_q      <= NO_SLOT;
						any_off_q   <= 1'b0;
						all_zero_q  <= 1'b1;
						mask_q      <= '0;
						work_held_q <= held_q;
						cnt_q       <= '0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CW'(1);
					end
					best_q      <= n_best;
					pick_q      <= n_pick;
					any_off_q   <= n_any_off;
					all_zero_q  <= n_all_zero;
					mask_q      <= n_mask;
					work_held_q <= n_held;
					if (vld_s1 && idx_s1 == LAST_IDX) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						held_q   <= fin_held;
						m_tvalid <= 1'b1;
						m_tdata  <= {1'b0, fin_ind, fin_held, pick_q, mask_q};
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`include "heartbeat_timeout_alarm_select_unit_assert.svh"

	`HTAS_ASSERT_NOW(a_result_from_fin, $rose(m_tvalid), $past(state_q == ST_FIN),
		"result raised outside the finishing state")
	`HTAS_ASSERT_NEXT(a_scan_starts_at_zero, in_xfer && in_req == REQ_SCAN,
		state_q == ST_SCAN && cnt_q == '0, "scan did not start at entry zero")
	`HTAS_ASSERT_NOW(a_pick_needs_offline, state_q == ST_FIN && pick_q != NO_SLOT, any_off_q,
		"alarm entry selected with no entry offline")

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - heartbeat timeout alarm select unit
// drives set-up, heartbeat, scan and unused-code transfers through the input stream and
// checks each scan report against an in-bench copy of the device table
// ----------------------------------------------------------------------------

module testbench;
	import htas_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int NUM_SLOTS   = 16;
	localparam int RAND_ITEMS  = 1850;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct {
		logic [1:0]  req;
		logic [31:0] stamp;
		logic [3:0]  slot;
		cfg_entry_t  cfg;
	} req_item_t;

	typedef struct {
		logic [MASK_W-1:0] mask;
		logic [PICK_W-1:0] slot;
		logic [7:0]        beep;
		logic [1:0]        ind;
	} alarm_rpt_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	req_item_t  req_backlog[$];
	alarm_rpt_t alarm_due[$];

	// device table as the block should hold it
	cfg_entry_t  dev_cfg[NUM_SLOTS];
	logic [31:0] dev_seen[NUM_SLOTS];
	logic [7:0]  held_beep;

	int err_cnt = 0;
	int sent_cnt = 0;
	int item_total = 1;
	int idle_cycles = 0;
	int load_phase;
	int send_gap_pct;
	int recv_stall_pct;

	heartbeat_timeout_alarm_select_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	task automatic add_req(input logic [1:0] req, input logic [31:0] stamp,
			input logic [3:0] slot, input logic [15:0] tmo, input logic [7:0] lvl,
			input logic [7:0] beep, input logic en);
		req_item_t it;
		it.req = req;
		it.stamp = stamp;
		it.slot = slot;
		it.cfg.timeout = tmo;
		it.cfg.level = lvl;
		it.cfg.beep = beep;
		it.cfg.enable = en;
		req_backlog.push_back(it);
	endtask

	// four load phases over the run: none, sender gaps, receiver stalls, both
	always_comb begin
		load_phase = sent_cnt * 4 / item_total;
		if (load_phase > 3)
			load_phase = 3;
		send_gap_pct = (load_phase == 1) ? 61 : (load_phase == 3) ? 27 : 0;
		recv_stall_pct = (load_phase == 2) ? 61 : (load_phase == 3) ? 27 : 0;
	end

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (req_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				req_item_t it;
				it = req_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= it.req;
				s_tdata <= {3'b000, it.cfg, it.slot, it.stamp};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: check reports, then fold each accepted request into the table
	always @(posedge clk) begin : monitor
		alarm_rpt_t  want;
		alarm_rpt_t  got;
		logic [31:0] now;
		logic [31:0] elapsed;
		logic [7:0]  best;
		logic        any_off;
		logic        all_zero;
		logic [3:0]  slot;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.mask = m_tdata[15:0];
				got.slot = m_tdata[20:16];
				got.beep = m_tdata[28:21];
				got.ind  = m_tdata[30:29];
				if (alarm_due.size() == 0) begin
					report_mismatch($sformatf("unexpected report 0x%08h", m_tdata));
				end else begin
					want = alarm_due.pop_front();
					if (got.mask !== want.mask)
						report_mismatch($sformatf("offline_mask got 0x%04h want 0x%04h",
							got.mask, want.mask));
					if (got.slot !== want.slot)
						report_mismatch($sformatf("alarm_slot got %0d want %0d",
							got.slot, want.slot));
					if (got.beep !== want.beep)
						report_mismatch($sformatf("alarm_beep_count got %0d want %0d",
							got.beep, want.beep));
					if (got.ind !== want.ind)
						report_mismatch($sformatf("indicator got %0d want %0d",
							got.ind, want.ind));
				end
			end
			if (s_tvalid && s_tready) begin
				sent_cnt++;
				now = s_tdata[31:0];
				slot = s_tdata[35:32];
				case (s_tuser)
					REQ_BEAT: begin
						dev_seen[slot] = now;
					end
					REQ_SETUP: begin
						dev_cfg[slot] = s_tdata[68:36];
					end
					REQ_SCAN: begin
						best = 8'd0;
						want.slot = NO_SLOT;
						want.mask = '0;
						any_off = 1'b0;
						all_zero = 1'b1;
						for (int k = 0; k < NUM_SLOTS; k++) begin
							elapsed = now - dev_seen[k];
							if (dev_cfg[k].enable && elapsed > {16'd0, dev_cfg[k].timeout}) begin
								any_off = 1'b1;
								want.mask[k] = 1'b1;
								if (dev_cfg[k].level > best) begin
									best = dev_cfg[k].level;
									want.slot = k[PICK_W-1:0];
									held_beep = dev_cfg[k].beep;
									all_zero = (dev_cfg[k].beep == 8'd0);
								end else if (dev_cfg[k].level == best && dev_cfg[k].beep != 8'd0) begin
									// held count from earlier scans still competes here
									all_zero = 1'b0;
									if (held_beep == 8'd0 || dev_cfg[k].beep < held_beep) begin
										want.slot = k[PICK_W-1:0];
										held_beep = dev_cfg[k].beep;
									end
								end
							end
						end
						if (want.slot != NO_SLOT && any_off && !all_zero) begin
							want.ind = IND_BEEP;
						end else if (any_off && all_zero) begin
							want.ind = IND_RED;
						end else begin
							held_beep = 8'd0;
							want.ind = IND_GREEN;
						end
						want.beep = held_beep;
						alarm_due.push_back(want);
					end
					default: ;
				endcase
			end
		end
	end

	// watchdog on accepted transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("FAIL heartbeat_timeout_alarm_select_unit");
		$finish;
	end

	initial begin
		logic [31:0] clock_now;
		logic [1:0]  req;
		logic [15:0] tmo;
		logic [7:0]  lvl;
		logic [7:0]  beep;
		int          made;
		int          pick;

		for (int k = 0; k < NUM_SLOTS; k++) begin
			dev_cfg[k] = '0;
			dev_seen[k] = '0;
		end
		held_beep = 8'd0;

		// directed: all-green at reset, extremes, wrap of elapsed time, level ties
		add_req(REQ_SCAN,  32'h0000_0000, 4'd0,  16'd0,     8'd0,   8'd0,   1'b0);
		add_req(REQ_SETUP, 32'hFFFF_FFFF, 4'd0,  16'd0,     8'd255, 8'd255, 1'b1);
		add_req(REQ_SETUP, 32'h5555_AAAA, 4'd15, 16'hFFFF,  8'd255, 8'd1,   1'b1);
		add_req(REQ_SETUP, 32'h0000_0000, 4'd7,  16'd10,    8'd0,   8'd0,   1'b1);
		add_req(REQ_BEAT,  32'hFFFF_FFF0, 4'd0,  16'hFFFF,  8'hFF,  8'hFF,  1'b1);
		add_req(REQ_BEAT,  32'hFFFF_FFFF, 4'd15, 16'd0,     8'd0,   8'd0,   1'b0);
		add_req(REQ_BEAT,  32'h0000_0000, 4'd7,  16'd0,     8'd0,   8'd0,   1'b0);
		add_req(REQ_SCAN,  32'hFFFF_FFF0, 4'd0,  16'd0,     8'd0,   8'd0,   1'b0);
		add_req(REQ_SCAN,  32'h0000_0005, 4'd15, 16'hFFFF,  8'hFF,  8'hFF,  1'b1);
		add_req(REQ_NONE,  32'hFFFF_FFFF, 4'd15, 16'hFFFF,  8'hFF,  8'hFF,  1'b1);
		add_req(REQ_SETUP, 32'h0000_0000, 4'd3,  16'd0,     8'd255, 8'd0,   1'b1);
		add_req(REQ_SCAN,  32'h8000_0000, 4'd0,  16'd0,     8'd0,   8'd0,   1'b0);
		add_req(REQ_SETUP, 32'h0000_0000, 4'd0,  16'd0,     8'd255, 8'd255, 1'b0);
		add_req(REQ_SETUP, 32'hDEAD_BEEF, 4'd4,  16'd0,     8'd255, 8'd1,   1'b1);
		add_req(REQ_SCAN,  32'h1234_5678, 4'd0,  16'd0,     8'd0,   8'd0,   1'b0);
		add_req(REQ_SETUP, 32'h0000_0000, 4'd3,  16'd0,     8'd0,   8'd0,   1'b0);
		add_req(REQ_SETUP, 32'h0000_0000, 4'd4,  16'd0,     8'd0,   8'd0,   1'b0);
		add_req(REQ_SETUP, 32'h0000_0000, 4'd15, 16'd0,     8'd0,   8'd0,   1'b0);
		add_req(REQ_SCAN,  32'h1234_5678, 4'd0,  16'd0,     8'd0,   8'd0,   1'b0);
		add_req(REQ_SETUP, 32'h0000_0000, 4'd7,  16'd0,     8'd0,   8'd0,   1'b0);
		add_req(REQ_SCAN,  32'hFFFF_FFFF, 4'd0,  16'd0,     8'd0,   8'd0,   1'b0);

		// random: a running clock with heartbeats, set-ups and scans, plus noise
		clock_now = 32'hFFFF_FC00;
		made = 0;
		while (made < RAND_ITEMS) begin
			pick = $urandom_range(99);
			tmo = ($urandom_range(9) < 7) ? 16'($urandom_range(60)) : 16'($urandom);
			lvl = ($urandom_range(9) < 7) ? 8'($urandom_range(3)) : 8'($urandom);
			beep = ($urandom_range(9) < 6) ? 8'($urandom_range(3)) : 8'($urandom);
			if (pick < 3) begin
				add_req(REQ_NONE, $urandom, 4'($urandom), 16'($urandom), 8'($urandom),
					8'($urandom), 1'($urandom));
			end else if (pick < 8) begin
				req = 2'($urandom_range(2));
				add_req(req, $urandom, 4'($urandom), 16'($urandom), 8'($urandom),
					8'($urandom), 1'($urandom));
				made++;
			end else if (pick < 30) begin
				add_req(REQ_SETUP, $urandom, 4'($urandom), tmo, lvl, beep,
					$urandom_range(99) < 85);
				made++;
			end else if (pick < 62) begin
				add_req(REQ_BEAT, clock_now, 4'($urandom), tmo, lvl, beep, 1'($urandom));
				clock_now += $urandom_range(20);
				made++;
			end else begin
				// an occasional long jump sends most entries offline at once
				if ($urandom_range(99) == 0)
					clock_now = $urandom;
				else
					clock_now += $urandom_range(40);
				add_req(REQ_SCAN, clock_now, 4'($urandom), tmo, lvl, beep, 1'($urandom));
				made++;
			end
		end
		item_total = req_backlog.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || s_tvalid)
			@(posedge clk);
		while (alarm_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (alarm_due.size() != 0)
			report_mismatch($sformatf("%0d reports never arrived", alarm_due.size()));
		if (err_cnt == 0)
			$display("PASS heartbeat_timeout_alarm_select_unit");
		else
			$display("FAIL heartbeat_timeout_alarm_select_unit");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/htas_pkg.sv
sv/heartbeat_timeout_alarm_select_unit.sv
dv/testbench.sv
